### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only
`define KPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define KPC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/kpc_pkg.sv
`default_nettype none
package kpc_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    // Wide enough for diagonal index and board sizes at the largest parameter values
    localparam int CTRL_W  = 10;
    localparam int COUNT_W = 64;
    localparam int IN_W    = 7;

    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        logic              clear;
        logic              step;
        logic [CTRL_W-1:0] diag;
        logic [CTRL_W-1:0] rows;
        logic [CTRL_W-1:0] cols;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } kpc_state_t;

endpackage
`default_nettype wire

### src/kpc_cell.sv
`default_nettype none
module kpc_cell
    import kpc_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  wire        clk,
    input  cell_ctrl_t ctrl,
    input  count_t     up1_h3,   // row-1, three diagonals back
    input  count_t     dn1_h1,   // row+1, previous diagonal
    input  count_t     up2_h3,   // row-2, three diagonals back
    input  count_t     up2_h1,   // row-2, previous diagonal
    output count_t     h1,
    output count_t     h3,
    output count_t     value,
    output logic       ovf
);

    localparam logic [CTRL_W-1:0] MY_ROW = CTRL_W'(IDX);

    count_t h1_reg, h2_reg, h3_reg;
    logic   valid, start;
    logic [COUNT_W:0]   s_lo, s_hi;
    logic [COUNT_W+1:0] s_all;
    logic   sat;
    count_t v_sat;

    always_comb
    begin
        valid = (MY_ROW < ctrl.rows) && (ctrl.diag >= MY_ROW)
             && ((ctrl.diag - MY_ROW) < ctrl.cols);
        start = (IDX == 0) && (ctrl.diag == '0);
        // Saturating one add at a time ends at the clamped full sum, so add as a tree
        s_lo  = {1'b0, up1_h3} + {1'b0, dn1_h1};
        s_hi  = {1'b0, up2_h3} + {1'b0, up2_h1};
        s_all = {1'b0, s_lo} + {1'b0, s_hi};
        sat   = |s_all[COUNT_W+1:COUNT_W];
        v_sat = sat ? '1 : s_all[COUNT_W-1:0];
        if (!valid)
        begin
            value = '0;
        end
        else if (start)
        begin
            value = count_t'(1);
        end
        else
        begin
            value = v_sat;
        end
        ovf = valid && !start && sat;
    end

    // Shift own row history by one diagonal per step
    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            h1_reg <= '0;
            h2_reg <= '0;
            h3_reg <= '0;
        end
        else if (ctrl.step)
        begin
            h1_reg <= value;
            h2_reg <= h1_reg;
            h3_reg <= h2_reg;
        end
    end

    assign h1 = h1_reg;
    assign h3 = h3_reg;

endmodule
`default_nettype wire

### src/knight_path_count_dp.sv
// Counts restricted knight paths from the top-left to the bottom-right cell of a
// rows x cols board, one result per transfer. A row of MAX_ROWS cells, one per board
// row, sweeps diagonals 0 to rows + cols - 2 one anti-diagonal per clock, holding on
// the last while the previous result still waits; an empty board ends on its first
// step. Sizes above MAX_ROWS / MAX_COLS are clamped. Counts saturate at 2^64-1 and
// set the overflow flag. The next item is taken while the result waits on the output.
`default_nettype none
`include "assert_macros.svh"
module knight_path_count_dp
    import kpc_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // rows [6:0], cols [13:7], zero [15:14]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,   // paths [63:0]
    output logic        m_tuser    // overflow [0]
);

    localparam int IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [CTRL_W-1:0] ROWS_LIM = CTRL_W'(MAX_ROWS);
    localparam logic [CTRL_W-1:0] COLS_LIM = CTRL_W'(MAX_COLS);

    kpc_state_t state_reg, state_next;
    logic [CTRL_W-1:0] diag_reg, last_reg, rows_reg, cols_reg;
    logic              empty_reg, ovf_reg, out_valid_reg;
    count_t            paths_reg;
    logic              out_ovf_reg;

    logic              accept, fin, out_busy, step, any_ovf;
    logic [CTRL_W-1:0] rows_in, cols_in, rows_c, cols_c;
    logic [CTRL_W-1:0] sel_row;
    cell_ctrl_t        ctrl;

    count_t h1_arr [MAX_ROWS];
    count_t h3_arr [MAX_ROWS];
    count_t v_arr  [MAX_ROWS];
    logic [MAX_ROWS-1:0] ovf_vec;

    assign rows_in = CTRL_W'(s_tdata[IN_W-1:0]);
    assign cols_in = CTRL_W'(s_tdata[2*IN_W-1:IN_W]);
    assign rows_c  = (rows_in > ROWS_LIM) ? ROWS_LIM : rows_in;
    assign cols_c  = (cols_in > COLS_LIM) ? COLS_LIM : cols_in;

    assign accept   = s_tvalid && s_tready;
    assign out_busy = out_valid_reg && !m_tready;
    assign fin      = empty_reg || (diag_reg == last_reg);
    assign any_ovf  = |ovf_vec;
    assign sel_row  = rows_reg - CTRL_W'(1);

    always_comb
    begin
        ctrl.clear = accept;
        ctrl.step  = step;
        ctrl.diag  = diag_reg;
        ctrl.rows  = rows_reg;
        ctrl.cols  = cols_reg;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ROWS; g++)
        begin : g_cell
            count_t up1_h3, dn1_h1, up2_h3, up2_h1;
            if (g >= 1)
            begin : g_up1
                assign up1_h3 = h3_arr[g-1];
            end
            else
            begin : g_no_up1
                assign up1_h3 = '0;
            end
            if (g >= 2)
            begin : g_up2
                assign up2_h3 = h3_arr[g-2];
                assign up2_h1 = h1_arr[g-2];
            end
            else
            begin : g_no_up2
                assign up2_h3 = '0;
                assign up2_h1 = '0;
            end
            if (g + 1 < MAX_ROWS)
            begin : g_dn1
                assign dn1_h1 = h1_arr[g+1];
            end
            else
            begin : g_no_dn1
                assign dn1_h1 = '0;
            end
            kpc_cell #(.IDX(g)) u_cell (
                .clk    (clk),
                .ctrl   (ctrl),
                .up1_h3 (up1_h3),
                .dn1_h1 (dn1_h1),
                .up2_h3 (up2_h3),
                .up2_h1 (up2_h1),
                .h1     (h1_arr[g]),
                .h3     (h3_arr[g]),
                .value  (v_arr[g]),
                .ovf    (ovf_vec[g])
            );
        end
    endgenerate

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (fin && !out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine
    always_comb
    begin
        s_tready = 1'b0;
        step     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_RUN:
            begin
                step = !(fin && out_busy);
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (step && fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            diag_reg  <= '0;
            rows_reg  <= rows_c;
            cols_reg  <= cols_c;
            last_reg  <= rows_c + cols_c - CTRL_W'(2);
            empty_reg <= (rows_c == '0) || (cols_c == '0);
            ovf_reg   <= 1'b0;
        end
        else if (step)
        begin
            diag_reg <= diag_reg + CTRL_W'(1);
            ovf_reg  <= ovf_reg | any_ovf;
            if (fin)
            begin
                paths_reg   <= empty_reg ? '0 : v_arr[sel_row[IW-1:0]];
                out_ovf_reg <= ovf_reg | any_ovf;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = paths_reg;
    assign m_tuser  = out_ovf_reg;

    `KPC_ASSERT_ALWAYS(a_no_take_in_run, (state_reg == ST_RUN) |-> !s_tready,
        "input taken during a sweep")
    `KPC_ASSERT(a_accept_runs, accept |=> (state_reg == ST_RUN) && (diag_reg == '0),
        "accepted item did not start a sweep")
    `KPC_ASSERT(a_result_on_finish, (step && fin) |=> m_tvalid,
        "finished sweep produced no result")
    `KPC_ASSERT(a_hold_when_busy, (state_reg == ST_RUN && fin && out_busy) |=> $stable(diag_reg),
        "sweep advanced while result still waiting")

endmodule
`default_nettype wire
